[hdl/xpr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package xpr_pkg;

  localparam int XPR_PATH_DEPTH = 256;
  localparam int DIV_DVD_W      = 48;
  localparam int DIV_DVS_W      = 32;

  localparam logic [2:0] FUNC_TICK       = 3'd0;
  localparam logic [2:0] FUNC_REC_START  = 3'd1;
  localparam logic [2:0] FUNC_REC_STOP   = 3'd2;
  localparam logic [2:0] FUNC_PLAY       = 3'd3;
  localparam logic [2:0] FUNC_PLAY_STOP  = 3'd4;
  localparam logic [2:0] FUNC_CLEAR      = 3'd5;

  localparam logic [1:0] CFG_LOOP_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_MOVE_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_TIME_GAP       = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] beat;
    logic [15:0] pad_x;
    logic [15:0] pad_y;
  } in_t;

  typedef struct packed {
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic        driven;
    logic        is_recording;
    logic        is_playing;
    logic [8:0]  points_held;
    logic        overflowed;
  } out_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] tm;
  } point_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic apply_cmd;
    logic rd_last;
    logic rec_commit;
    logic stop_play;
    logic load_t;
    logic mod_start;
    logic mod_load;
    logic scan_clear;
    logic scan_step;
    logic frac_start;
    logic frac_zero;
    logic frac_load;
    logic lerp_x;
    logic lerp_y;
    logic finish;
    logic drive;
  } xpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] func;
    logic       recording;
    logic       playing;
    logic       n_lt2;
    logic       dur_zero;
    logic       past_end;
    logic       loop;
    logic       div_done;
    logic       found;
    logic       frac_need;
  } xpr_stat_t;

endpackage
`default_nettype wire

[hdl/xpr_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module xpr_div
  import xpr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 go,
  input  wire logic [DIV_DVD_W-1:0] dividend,
  input  wire logic [DIV_DVS_W-1:0] divisor,
  output logic      [DIV_DVD_W-1:0] quot,
  output logic      [DIV_DVS_W-1:0] rem,
  output logic                      done
);

  localparam int CNT_W = $clog2(DIV_DVD_W);

  logic [DIV_DVD_W-1:0] q_r, q_nxt;
  logic [DIV_DVS_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r, done_r;
  logic [DIV_DVS_W:0]   sh;

  // One restoring step per cycle, quotient bits shift in as the dividend shifts out.
  always_comb begin
    sh = {rem_r, q_r[DIV_DVD_W-1]};
    if (sh >= {1'b0, dvs_r}) begin
      rem_nxt = DIV_DVS_W'(sh - {1'b0, dvs_r});
      q_nxt   = {q_r[DIV_DVD_W-2:0], 1'b1};
    end else begin
      rem_nxt = sh[DIV_DVS_W-1:0];
      q_nxt   = {q_r[DIV_DVD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot = q_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule
`default_nettype wire

[hdl/xpr_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module xpr_dp
  import xpr_pkg::*;
#(
  parameter int PATH_DEPTH = XPR_PATH_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire in_t         in_word,
  input  wire logic        loop_enable,
  input  wire logic [15:0] move_threshold,
  input  wire logic [19:0] time_gap,
  input  wire xpr_cmd_t    cmd,
  output xpr_stat_t        stat,
  output logic             out_valid,
  output out_t             out_word
);

  localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int CW = $clog2(PATH_DEPTH + 1);

  point_t mem [PATH_DEPTH];
  point_t rd_q, prev_r, cur_r;

  in_t          in_r;
  logic [31:0]  start_r, rel_r, t_r;
  logic [CW-1:0] total_r, idx_r;
  logic         rec_r, play_r, ovf_r;
  logic         rd_vld_r, rd_first_r;
  logic [16:0]  f_r;
  logic signed [34:0] prod_r;
  logic [15:0]  ox_r;
  out_t         out_r;
  logic         out_valid_r;

  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en, take;
  logic [15:0]   dx, dy;
  logic signed [32:0] gap_s;
  logic [DIV_DVD_W-1:0] dvd;
  logic [DIV_DVS_W-1:0] dvs;
  logic [DIV_DVD_W-1:0] quot;
  logic [DIV_DVS_W-1:0] rem;
  logic          div_done;
  logic [31:0]   rel_w;
  logic signed [16:0] lx_diff, ly_diff;
  logic [15:0]   lerp_res;
  logic signed [36:0] v;

  assign rel_w = (in_word.beat >= start_r) ? in_word.beat - start_r : 32'd0;

  // Point store: one write and one registered read per cycle.
  assign rd_addr = cmd.rd_last ? AW'(total_r - CW'(1)) : AW'(idx_r);
  assign wr_addr = AW'(total_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{x: in_r.pad_x, y: in_r.pad_y, tm: rel_r};
    end
    rd_q <= mem[rd_addr];
  end

  assign dx    = (rd_q.x >= in_r.pad_x) ? rd_q.x - in_r.pad_x : in_r.pad_x - rd_q.x;
  assign dy    = (rd_q.y >= in_r.pad_y) ? rd_q.y - in_r.pad_y : in_r.pad_y - rd_q.y;
  assign gap_s = $signed({1'b0, rel_r}) - $signed({1'b0, rd_q.tm});
  assign take  = (total_r == '0) || (dx > move_threshold) || (dy > move_threshold) ||
                 (gap_s > $signed({13'b0, time_gap}));
  assign wr_en = cmd.rec_commit && take && (total_r < CW'(PATH_DEPTH));

  // The shared divider serves the end-of-path wrap and the interpolation fraction.
  always_comb begin
    if (cmd.mod_start) begin
      dvd = {16'b0, rel_r};
      dvs = rd_q.tm;
    end else begin
      dvd = {t_r - prev_r.tm, 16'b0};
      dvs = cur_r.tm - prev_r.tm;
    end
  end

  xpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.mod_start | cmd.frac_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quot     (quot),
    .rem      (rem),
    .done     (div_done)
  );

  assign lx_diff = $signed({1'b0, cur_r.x}) - $signed({1'b0, prev_r.x});
  assign ly_diff = $signed({1'b0, cur_r.y}) - $signed({1'b0, prev_r.y});

  // The x result is formed in the cycle after its product, the y result at finish.
  always_comb begin
    if (cmd.lerp_y) begin
      v = $signed({5'b0, prev_r.x, 16'b0}) + 37'(prod_r) + 37'sd32768;
    end else begin
      v = $signed({5'b0, prev_r.y, 16'b0}) + 37'(prod_r) + 37'sd32768;
    end
    if (v < 0) begin
      lerp_res = 16'd0;
    end else if (v[36:32] != '0) begin
      lerp_res = 16'hFFFF;
    end else begin
      lerp_res = v[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      rec_r       <= 1'b0;
      play_r      <= 1'b0;
      ovf_r       <= 1'b0;
      start_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.apply_cmd) begin
        unique case (in_r.func)
          FUNC_REC_START: begin
            total_r <= '0;
            ovf_r   <= 1'b0;
            rec_r   <= 1'b1;
            play_r  <= 1'b0;
            start_r <= in_r.beat;
          end
          FUNC_REC_STOP: rec_r <= 1'b0;
          FUNC_PLAY: begin
            if (total_r != '0) begin
              play_r  <= 1'b1;
              rec_r   <= 1'b0;
              start_r <= in_r.beat;
            end
          end
          FUNC_PLAY_STOP: play_r <= 1'b0;
          FUNC_CLEAR: begin
            total_r <= '0;
            ovf_r   <= 1'b0;
            play_r  <= 1'b0;
            rec_r   <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.rec_commit && take) begin
        if (total_r < CW'(PATH_DEPTH)) begin
          total_r <= total_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.stop_play) begin
        play_r <= 1'b0;
      end
      if (cmd.scan_clear) begin
        rd_vld_r <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r  <= in_word;
      rel_r <= rel_w;
    end
    if (cmd.load_t) begin
      t_r <= rel_r;
    end else if (cmd.mod_load) begin
      t_r <= rem;
    end
    if (cmd.scan_clear) begin
      idx_r <= '0;
    end else if (cmd.scan_step) begin
      idx_r      <= idx_r + 1'b1;
      rd_first_r <= (idx_r == '0);
      if (rd_vld_r) begin
        if (rd_first_r || rd_q.tm < t_r) begin
          prev_r <= rd_q;
        end else begin
          cur_r <= rd_q;
        end
      end
    end
    if (cmd.frac_zero) begin
      f_r <= '0;
    end else if (cmd.frac_load) begin
      f_r <= quot[16:0];
    end
    if (cmd.lerp_x) begin
      prod_r <= lx_diff * $signed({1'b0, f_r});
    end else if (cmd.lerp_y) begin
      prod_r <= ly_diff * $signed({1'b0, f_r});
      ox_r   <= lerp_res;
    end
    if (cmd.finish) begin
      out_r.out_x        <= cmd.drive ? ox_r : in_r.pad_x;
      out_r.out_y        <= cmd.drive ? lerp_res : in_r.pad_y;
      out_r.driven       <= cmd.drive;
      out_r.is_recording <= rec_r;
      out_r.is_playing   <= play_r;
      out_r.points_held  <= 9'(total_r);
      out_r.overflowed   <= ovf_r;
    end
  end

  assign stat.func      = in_r.func;
  assign stat.recording = rec_r;
  assign stat.playing   = play_r;
  assign stat.n_lt2     = total_r < CW'(2);
  assign stat.dur_zero  = rd_q.tm == '0;
  assign stat.past_end  = rel_r > rd_q.tm;
  assign stat.loop      = loop_enable;
  assign stat.div_done  = div_done;
  assign stat.found     = rd_vld_r && !rd_first_r && (rd_q.tm >= t_r);
  assign stat.frac_need = (cur_r.tm > prev_r.tm) && (t_r > prev_r.tm);

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule
`default_nettype wire

[hdl/xpr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module xpr_ctrl
  import xpr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire xpr_stat_t stat,
  output xpr_cmd_t       cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DISPATCH = 12'b0000_0000_0010,
    S_CHK_REC  = 12'b0000_0000_0100,
    S_CHK_PLAY = 12'b0000_0000_1000,
    S_MOD      = 12'b0000_0001_0000,
    S_SCAN     = 12'b0000_0010_0000,
    S_FRAC     = 12'b0000_0100_0000,
    S_FDIV     = 12'b0000_1000_0000,
    S_LX       = 12'b0001_0000_0000,
    S_LY       = 12'b0010_0000_0000,
    S_FIN      = 12'b0100_0000_0000,
    S_FIN_DRV  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.func == FUNC_TICK) begin
          cmd.rd_last = 1'b1;
          if (stat.recording) begin
            state_nxt = S_CHK_REC;
          end else if (stat.playing && !stat.n_lt2) begin
            state_nxt = S_CHK_PLAY;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          cmd.apply_cmd = 1'b1;
          state_nxt     = S_FIN;
        end
      end
      S_CHK_REC: begin
        cmd.rec_commit = 1'b1;
        state_nxt      = S_FIN;
      end
      S_CHK_PLAY: begin
        if (stat.dur_zero) begin
          state_nxt = S_FIN;
        end else if (stat.past_end && !stat.loop) begin
          cmd.stop_play = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          cmd.load_t     = 1'b1;
          cmd.scan_clear = 1'b1;
          if (stat.past_end) begin
            cmd.mod_start = 1'b1;
            state_nxt     = S_MOD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_MOD: begin
        if (stat.div_done) begin
          cmd.mod_load = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.found) begin
          state_nxt = S_FRAC;
        end
      end
      S_FRAC: begin
        if (stat.frac_need) begin
          cmd.frac_start = 1'b1;
          state_nxt      = S_FDIV;
        end else begin
          cmd.frac_zero = 1'b1;
          state_nxt     = S_LX;
        end
      end
      S_FDIV: begin
        if (stat.div_done) begin
          cmd.frac_load = 1'b1;
          state_nxt     = S_LX;
        end
      end
      S_LX: begin
        cmd.lerp_x = 1'b1;
        state_nxt  = S_LY;
      end
      S_LY: begin
        cmd.lerp_y = 1'b1;
        state_nxt  = S_FIN_DRV;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_FIN_DRV: begin
        cmd.finish = 1'b1;
        cmd.drive  = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule
`default_nettype wire

[hdl/xy_path_record_playback.sv]
// Commands and ticks with nothing to do: dispatch, then finish, then the registered result strobe.
// A recording tick adds the record check. A playing tick adds a scan over the n stored points,
// a divider run when the play time wraps and at most one fraction divide; the point scan (one
// store read a cycle) and the 48-step shared divider set its length. One word is in flight at a
// time (busy high). The receiver cannot stall; out_valid is high for one cycle per word.
// Reset clears the flags, the point count and the start beat; the point store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module xy_path_record_playback
  import xpr_pkg::*;
#(
  parameter int PATH_DEPTH = XPR_PATH_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_t         in_word,
  output logic             out_valid,
  output out_t             out_word,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  logic        loop_r;
  logic [15:0] thr_r;
  logic [19:0] gap_r;
  xpr_cmd_t    cmd;
  xpr_stat_t   stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_r <= 1'b0;
      thr_r  <= 16'd131;
      gap_r  <= 20'd16384;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOOP_ENABLE:    loop_r <= cfg_data[0];
        CFG_MOVE_THRESHOLD: thr_r  <= cfg_data[15:0];
        CFG_TIME_GAP:       gap_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  xpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  xpr_dp #(
    .PATH_DEPTH (PATH_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_word        (in_word),
    .loop_enable    (loop_r),
    .move_threshold (thr_r),
    .time_gap       (gap_r),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_word       (out_word)
  );

endmodule
`default_nettype wire
